// ===== rtl/wvfe_pkg.sv =====
// package for the wavetable voice: widths, register indexes, item codes, limits
// no dependencies
package wvfe_pkg;
    localparam int TableSize = 256;
    localparam int TableAw   = 8;
    localparam int EchoDepth = 4096;
    localparam int EchoAw    = 12;
    localparam int PhaseBits = 24;

    localparam logic [2:0] CfgPhaseStep = 3'd0;
    localparam logic [2:0] CfgVolume    = 3'd1;
    localparam logic [2:0] CfgNoise     = 3'd2;
    localparam logic [2:0] CfgFeedback  = 3'd3;
    localparam logic [2:0] CfgFiltEn    = 3'd4;
    localparam logic [2:0] CfgB0        = 3'd5;
    localparam logic [2:0] CfgA1        = 3'd6;
    localparam logic [2:0] CfgA2        = 3'd7;

    localparam logic OpLoad = 1'b0;
    localparam logic OpGen  = 1'b1;

    localparam logic [15:0] Unity    = 16'd32768;
    localparam logic [15:0] LfsrSeed = 16'hACE1;
    localparam logic [15:0] LfsrTaps = 16'hB400;
    localparam logic signed [23:0] DeadZone = 24'sd21;

    // queued item between the front and the back
    typedef struct packed {
        logic                 op;
        logic [TableAw-1:0]   idx;
        logic signed [15:0]   val;
    } t_item;

    function automatic logic [15:0] cap_gain(input logic [15:0] g);
        cap_gain = (g > Unity) ? Unity : g;
    endfunction

    function automatic logic signed [23:0] sat20(input logic signed [47:0] x);
        if (x > 48'sd8388607) sat20 = 24'sd8388607;
        else if (x < -48'sd8388608) sat20 = -24'sd8388608;
        else sat20 = x[23:0];
    endfunction
endpackage

// ===== rtl/wvfe_ram.sv =====
// generic single port write, single port read ram with registered read
// no dependencies
module wvfe_ram #(
    parameter int Width = 16,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/wvfe_front.sv =====
// front: accepts items into a two-entry queue
// depends on wvfe_pkg
module wvfe_front import wvfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_opcode,
    input  logic [7:0] i_table_index,
    input  logic [15:0] i_table_value,
    output logic       o_q_valid,
    output t_item      o_q_item,
    input  logic       i_q_pop
);
    t_item r_ent [2];
    logic  r_rd, r_wr;
    logic [1:0] r_cnt;
    logic  push;
    t_item in_item;

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_ent[r_rd];

    always_comb begin
        in_item.op  = i_opcode;
        in_item.idx = i_table_index[TableAw-1:0];
        in_item.val = i_table_value;
    end

    always_ff @(posedge i_clk) begin
        if (push) r_ent[r_wr] <= in_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= 1'b0;
            r_wr <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_q_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule

// ===== rtl/wvfe_back.sv =====
// back: sequencer with one shared multiplier, wave table, echo memory, output register
// depends on wvfe_pkg, wvfe_ram
module wvfe_back import wvfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    input  logic [23:0] i_phase_step,
    input  logic [15:0] i_volume,
    input  logic [15:0] i_noise_level,
    input  logic [15:0] i_delay_feedback,
    input  logic        i_filter_enable,
    input  logic signed [17:0] i_coef_b0,
    input  logic signed [17:0] i_coef_a1,
    input  logic signed [17:0] i_coef_a2,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_sample
);
    typedef enum logic [18:0] {
        S_CLEAR = 19'h00001,
        S_IDLE  = 19'h00002,
        S_RD0   = 19'h00004,
        S_RD1   = 19'h00008,
        S_INT   = 19'h00010,
        S_SCL   = 19'h00020,
        S_DIV   = 19'h00040,
        S_NZ0   = 19'h00080,
        S_NZ1   = 19'h00100,
        S_NZ2   = 19'h00200,
        S_F0    = 19'h00400,
        S_F1    = 19'h00800,
        S_F2    = 19'h01000,
        S_F3    = 19'h02000,
        S_FEND  = 19'h04000,
        S_VOL   = 19'h08000,
        S_ECHO  = 19'h10000,
        S_FB    = 19'h20000,
        S_OUT   = 19'h40000
    } t_state;

    t_state r_state, n_state;
    logic [PhaseBits-1:0] r_phase;
    logic [EchoAw-1:0]    r_eptr;
    logic [EchoAw-1:0]    r_clr;
    logic [15:0]          r_lfsr;
    logic signed [23:0]   r_x1, r_x2, r_y1, r_y2;
    logic signed [15:0]   r_w0;
    logic signed [47:0]   r_acc;
    logic signed [23:0]   r_g, r_e;
    logic                 r_ovalid;
    logic [15:0]          r_sample;

    // shared multiplier, registered product
    logic signed [24:0]   mul_a;
    logic signed [18:0]   mul_b;
    logic signed [47:0]   r_prod;

    logic [TableAw-1:0] t_raddr;
    logic [15:0]        t_rdata;
    logic               t_we;
    logic [23:0]        e_rdata;
    logic               e_we;
    logic [23:0]        e_wdata;
    logic [EchoAw-1:0]  e_waddr;

    logic [PhaseBits-1:0] ph_next;
    logic [TableAw-1:0]   ph_idx;
    logic [15:0]          ph_frac;
    logic [15:0]          nl, vol, fb;
    logic [15:0]          lfsr_next;
    logic signed [47:0]   rsum;
    logic signed [47:0]   q15r, nz_q, y_q;
    logic signed [47:0]   quo;
    logic signed [47:0]   eo;
    logic signed [23:0]   e_dz;
    logic signed [47:0]   vv, vabs, qe, rem;

    assign nl  = cap_gain(i_noise_level);
    assign vol = cap_gain(i_volume);
    assign fb  = cap_gain(i_delay_feedback);
    assign ph_next = r_phase + i_phase_step;
    assign ph_idx  = r_phase[PhaseBits-1 -: TableAw];
    assign ph_frac = r_phase[PhaseBits-TableAw-1 -: 16];
    assign lfsr_next = r_lfsr[0] ? ((r_lfsr >> 1) ^ LfsrTaps) : (r_lfsr >> 1);

    assign t_we = o_q_pop && (i_q_item.op == OpLoad);

    wvfe_ram #(.Width(16), .Depth(TableSize)) u_table (
        .i_clk(i_clk), .i_we(t_we),
        .i_waddr(i_q_item.idx), .i_wdata(i_q_item.val),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    wvfe_ram #(.Width(24), .Depth(EchoDepth)) u_echo (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(r_eptr), .o_rdata(e_rdata)
    );

    assign t_raddr = (r_state == S_RD0) ? ph_idx : ph_idx + 1'b1;
    assign q15r = (r_prod + 48'sd16384) >>> 15;
    // noise mix and filter sums close with the last product still in r_prod
    assign nz_q = (r_acc + r_prod + 48'sd16384) >>> 15;
    assign y_q  = (r_acc + r_prod + 48'sd32768) >>> 16;
    // v*16/32767 toward zero: v*16 = q*32767 + r, reciprocal estimate then fixup
    always_comb begin
        vv   = r_acc <<< 4;
        vabs = vv[47] ? -vv : vv;
        qe   = (vabs >>> 15) + (vabs >>> 30);
        rem  = vabs - ((qe <<< 15) - qe);
        if (rem >= 48'sd32767) qe = qe + 48'sd1;
        if (rem >= 48'sd65534) qe = qe + 48'sd1;
        quo  = vv[47] ? -qe : qe;
    end
    assign rsum = q15r + {{24{e_rdata[23]}}, e_rdata};
    always_comb begin
        e_dz = sat20(rsum);
        if (e_dz > -DeadZone && e_dz < DeadZone) e_dz = '0;
    end
    assign eo = r_e * 48'sd32000;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_INT:  begin mul_a = {{9{t_rdata[15]}}, t_rdata} - {{9{r_w0[15]}}, r_w0};
                          mul_b = {3'b000, ph_frac}; end
            S_NZ0:  begin mul_a = {r_g[23], r_g}; mul_b = {3'b000, Unity - nl}; end
            S_NZ1:  begin mul_a = {5'd0, r_lfsr, 4'd0}; mul_b = {3'b000, nl}; end
            S_F0:   begin mul_a = {r_g[23], r_g} + {r_x2[23], r_x2};
                          mul_b = {i_coef_b0[17], i_coef_b0}; end
            S_F1:   begin mul_a = {r_x1, 1'b0}; mul_b = {i_coef_b0[17], i_coef_b0}; end
            S_F2:   begin mul_a = {r_y1[23], r_y1}; mul_b = -{i_coef_a1[17], i_coef_a1}; end
            S_F3:   begin mul_a = {r_y2[23], r_y2}; mul_b = -{i_coef_a2[17], i_coef_a2}; end
            S_VOL:  begin mul_a = {r_g[23], r_g}; mul_b = {3'b000, vol}; end
            S_FB:   begin mul_a = {r_e[23], r_e}; mul_b = {3'b000, fb}; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) r_prod <= mul_a * mul_b;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid &&
                     (i_q_item.op == OpLoad || !r_ovalid);
    assign e_we    = (r_state == S_CLEAR) || (r_state == S_OUT);
    assign e_waddr = (r_state == S_CLEAR) ? r_clr : r_eptr;
    assign e_wdata = (r_state == S_CLEAR) ? 24'd0 : sat20(q15r);

    assign o_valid  = r_ovalid;
    assign o_sample = r_sample;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == EchoAw'(EchoDepth - 1)) n_state = S_IDLE;
            S_IDLE:  if (o_q_pop && i_q_item.op == OpGen) n_state = S_RD0;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_INT;
            S_INT:   n_state = S_SCL;
            S_SCL:   n_state = S_DIV;
            S_DIV:   n_state = (nl != 16'd0) ? S_NZ0 : (i_filter_enable ? S_F0 : S_VOL);
            S_NZ0:   n_state = S_NZ1;
            S_NZ1:   n_state = S_NZ2;
            S_NZ2:   n_state = i_filter_enable ? S_F0 : S_VOL;
            S_F0:    n_state = S_F1;
            S_F1:    n_state = S_F2;
            S_F2:    n_state = S_F3;
            S_F3:    n_state = S_FEND;
            S_FEND:  n_state = S_VOL;
            S_VOL:   n_state = S_ECHO;
            S_ECHO:  n_state = S_FB;
            S_FB:    n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_phase  <= '0;
            r_eptr   <= '0;
            r_lfsr   <= LfsrSeed;
            r_x1 <= '0; r_x2 <= '0; r_y1 <= '0; r_y2 <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == S_IDLE && n_state == S_RD0) r_phase <= ph_next;
            if (r_state == S_SCL && nl != 16'd0) r_lfsr <= lfsr_next;
            if (r_state == S_FEND) begin
                r_x2 <= r_x1; r_x1 <= r_g;
                r_y2 <= r_y1; r_y1 <= sat20(y_q);
            end
            if (r_state == S_OUT) begin
                r_eptr   <= r_eptr + 1'b1;
                r_ovalid <= 1'b1;
            end else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_RD1:  r_w0 <= t_rdata;
            S_SCL:  r_acc <= r_prod + ({{32{r_w0[15]}}, r_w0} <<< 16);
            S_DIV:  r_g <= sat20(quo);
            S_NZ1:  r_acc <= r_prod;
            S_NZ2:  r_g <= sat20(nz_q);
            S_F0:   r_acc <= '0;
            S_F1, S_F2, S_F3: r_acc <= r_acc + r_prod;
            S_FEND: r_g <= sat20(y_q);
            S_ECHO: r_e <= e_dz;
            S_OUT: begin
                if (eo < -48'sd34288435200) r_sample <= 16'd68;
                else if (eo > 48'sd34288435200) r_sample <= 16'd65468;
                else r_sample <= 16'((eo + 48'sd34359738368) >>> 20);
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/wavetable_voice_filter_echo.sv =====
// top level of the wavetable voice
// depends on wvfe_pkg, wvfe_front, wvfe_back, wvfe_ram
//
// channel  | handshake              | payload
// input    | i_valid / o_ready      | i_opcode, i_table_index, i_table_value
// output   | o_valid / i_ready      | o_sample
// config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// a generate beat steps the back sequencer through read, interpolate, scale, divide,
// noise when the noise level is nonzero, low-pass when enabled, volume, echo, feedback
// and output, in series on the one shared multiplier; a load beat is written in idle
// a generate beat waits in the queue until the previous sample is taken
// after reset the echo memory is cleared before items are taken
// a two-entry queue lets the front accept while the back or the output stalls
module wavetable_voice_filter_echo import wvfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_table_index,
    input  logic [15:0] i_table_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_sample,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    logic [23:0] r_phase_step;
    logic [15:0] r_volume, r_noise, r_fb;
    logic        r_fen;
    logic signed [17:0] r_b0, r_a1, r_a2;
    logic  q_valid, q_pop;
    t_item q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0; r_volume <= '0; r_noise <= '0; r_fb <= '0;
            r_fen <= 1'b0; r_b0 <= '0; r_a1 <= '0; r_a2 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CfgPhaseStep: r_phase_step <= i_cfg_data;
                CfgVolume:    r_volume <= i_cfg_data[15:0];
                CfgNoise:     r_noise <= i_cfg_data[15:0];
                CfgFeedback:  r_fb <= i_cfg_data[15:0];
                CfgFiltEn:    r_fen <= i_cfg_data[0];
                CfgB0:        r_b0 <= i_cfg_data[17:0];
                CfgA1:        r_a1 <= i_cfg_data[17:0];
                CfgA2:        r_a2 <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    wvfe_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_opcode, .i_table_index,
        .i_table_value, .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    wvfe_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .i_phase_step(r_phase_step), .i_volume(r_volume), .i_noise_level(r_noise),
        .i_delay_feedback(r_fb), .i_filter_enable(r_fen), .i_coef_b0(r_b0),
        .i_coef_a1(r_a1), .i_coef_a2(r_a2), .o_valid, .i_ready, .o_sample
    );
endmodule

// ===== tb/sv/wavetable_voice_filter_echo_tb.sv =====
// testbench for the wavetable voice: predicts each sample and checks it beat by beat
// depends on wvfe_pkg and wavetable_voice_filter_echo
`timescale 1ns / 100ps

module wavetable_voice_filter_echo_tb;
    import wvfe_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        in_op;
    logic [7:0]  in_idx;
    logic [15:0] in_val;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] out_sample;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    wavetable_voice_filter_echo dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_opcode(in_op), .i_table_index(in_idx), .i_table_value(in_val),
        .o_valid(out_valid), .i_ready(out_ready), .o_sample(out_sample),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // voice state mirror
    logic [23:0]        step_r;
    logic [15:0]        vol_r, noise_r, fb_r;
    logic               filt_r;
    logic signed [17:0] b0_r, a1_r, a2_r;
    logic [23:0]        phase;
    logic signed [15:0] wave [256];
    logic signed [23:0] echo [4096];
    logic [11:0]        echo_ptr;
    logic signed [23:0] fx1, fx2, fy1, fy2;
    logic [15:0]        lfsr;

    t_item       pending_beats[$];
    logic [15:0] expected_samples[$];
    int          errors;
    int          send_idle, recv_idle;

    function automatic longint sat_q20(input longint x);
        if (x > 64'sd8388607) return 64'sd8388607;
        if (x < -64'sd8388608) return -64'sd8388608;
        return x;
    endfunction

    function automatic longint rshift_round(input longint x, input int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint capped(input logic [15:0] g);
        return (g > 16'd32768) ? 32768 : longint'(g);
    endfunction

    // runs one beat through the mirror, returns 1 when a sample is produced
    function automatic bit voice_step(input t_item it, output logic [15:0] smp);
        logic [31:0] pos;
        int          idx;
        longint      w0, w1, v, g, nl, acc, y, e, o;
        smp = '0;
        if (it.op == OpLoad) begin
            wave[it.idx] = it.val;
            return 0;
        end
        phase = phase + step_r;
        pos = {phase, 8'd0};
        idx = int'(pos[31:24]);
        w0 = wave[idx];
        w1 = wave[(idx + 1) % 256];
        v = w0 * 65536 + (w1 - w0) * longint'(pos[23:8]);
        g = sat_q20((v * 16) / 32767);
        nl = capped(noise_r);
        if (nl != 0) begin
            lfsr = lfsr[0] ? ((lfsr >> 1) ^ LfsrTaps) : (lfsr >> 1);
            g = sat_q20(rshift_round(g * (32768 - nl) + longint'(lfsr) * 16 * nl, 15));
        end
        if (filt_r) begin
            acc = b0_r * g + 2 * b0_r * fx1 + b0_r * fx2 - a1_r * fy1 - a2_r * fy2;
            y = sat_q20(rshift_round(acc, 16));
            fx2 = fx1; fx1 = 24'(g); fy2 = fy1; fy1 = 24'(y);
            g = y;
        end
        e = sat_q20(rshift_round(g * capped(vol_r), 15) + echo[echo_ptr]);
        if (e > -21 && e < 21) e = 0;
        echo[echo_ptr] = 24'(sat_q20(rshift_round(e * capped(fb_r), 15)));
        echo_ptr = echo_ptr + 12'd1;
        o = e * 32000;
        if (o < -64'sd32700 * 1048576) o = -64'sd32700 * 1048576;
        if (o > 64'sd32700 * 1048576) o = 64'sd32700 * 1048576;
        o = o + 64'sd32768 * 1048576;
        smp = o[35:20];
        return 1;
    endfunction

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // input driver
    always @(posedge clk) begin
        logic [15:0] smp;
        if (!rst_n) begin
            in_valid <= 0;
        end else begin
            if (in_valid && in_ready) begin
                if (voice_step(pending_beats.pop_front(), smp))
                    expected_samples.push_back(smp);
            end
            if ((!in_valid || in_ready) && pending_beats.size() > 0
                    && $urandom_range(99) >= send_idle) begin
                in_valid <= 1;
                in_op <= pending_beats[0].op;
                in_idx <= pending_beats[0].idx;
                in_val <= pending_beats[0].val;
            end else if (!in_valid || in_ready) begin
                in_valid <= 0;
            end
        end
    end

    // sample monitor
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected sample, expected none, actual %0d",
                             $time, out_sample);
                    errors++;
                end else if (out_sample !== expected_samples[0]) begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $time, expected_samples[0], out_sample);
                    errors++;
                    void'(expected_samples.pop_front());
                end else begin
                    void'(expected_samples.pop_front());
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        case (idx)
            CfgPhaseStep: step_r = data;
            CfgVolume:    vol_r = data[15:0];
            CfgNoise:     noise_r = data[15:0];
            CfgFeedback:  fb_r = data[15:0];
            CfgFiltEn:    filt_r = data[0];
            CfgB0:        b0_r = data[17:0];
            CfgA1:        a1_r = data[17:0];
            CfgA2:        a2_r = data[17:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic push_beat(input logic op, input logic [7:0] idx, input logic [15:0] val);
        t_item it;
        it.op = op;
        it.idx = idx;
        it.val = val;
        pending_beats.push_back(it);
    endtask

    task automatic drain;
        while (pending_beats.size() > 0 || in_valid || expected_samples.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_regs(input bit extremes);
        write_reg(CfgPhaseStep, extremes ? 24'hFFFFFF : 24'($urandom));
        write_reg(CfgVolume, extremes ? 16'hFFFF : 16'($urandom_range(32768)));
        write_reg(CfgNoise, $urandom_range(3) == 0 ? 16'd0 : 16'($urandom));
        write_reg(CfgFeedback, extremes ? 16'd32768 : 16'($urandom_range(30000)));
        write_reg(CfgFiltEn, 24'($urandom_range(1)));
        // keep the low-pass stable most of the time: small b0, mild poles
        write_reg(CfgB0, extremes ? 24'h020000 : 24'(18'($urandom_range(20000))));
        write_reg(CfgA1, extremes ? 24'h01FFFF : 24'(-18'($urandom_range(90000))));
        write_reg(CfgA2, extremes ? 24'h020000 : 24'(18'($urandom_range(40000))));
    endtask

    task automatic run_phase(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0)
                push_beat(OpLoad, 8'($urandom), 16'($urandom));
            else
                push_beat(OpGen, 8'($urandom), 16'($urandom));
        end
        drain();
    endtask

    initial begin
        clk = 0;
        errors = 0;
        send_idle = 17;
        recv_idle = 87;
        rst_n = 0;
        in_valid = 0; in_op = 0; in_idx = 0; in_val = 0;
        out_ready = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        step_r = 0; vol_r = 0; noise_r = 0; fb_r = 0; filt_r = 0;
        b0_r = 0; a1_r = 0; a2_r = 0;
        phase = 0; echo_ptr = 0; lfsr = LfsrSeed;
        fx1 = 0; fx2 = 0; fy1 = 0; fy2 = 0;
        foreach (echo[i]) echo[i] = 0;
        foreach (wave[i]) wave[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // every table word is written before any generate beat reads it
        for (int i = 0; i < 256; i++)
            push_beat(OpLoad, 8'(i), (i == 0) ? 16'h8000 : (i == 255) ? 16'h7FFF
                                               : 16'($urandom));
        drain();

        // directed: silence, full scale, over-unity gains, filter extremes
        write_reg(CfgVolume, 16'd32768);
        write_reg(CfgPhaseStep, 24'h010000);
        for (int k = 0; k < 4; k++) push_beat(OpGen, 8'hFF, 16'hFFFF);
        push_beat(OpLoad, 8'h00, 16'h7FFF);
        push_beat(OpLoad, 8'h01, 16'h8000);
        push_beat(OpGen, 8'd0, 16'd0);
        drain();
        random_regs(1);
        for (int k = 0; k < 8; k++) push_beat(OpGen, 8'd0, 16'd0);
        drain();
        write_reg(CfgVolume, 16'd0);
        write_reg(CfgNoise, 16'd0);
        write_reg(CfgFeedback, 16'd0);
        write_reg(CfgFiltEn, 24'd0);
        write_reg(CfgPhaseStep, 24'd0);
        for (int k = 0; k < 4; k++) push_beat(OpGen, 8'd0, 16'd0);
        drain();

        for (int p = 0; p < 3; p++) begin
            if (p == 1) begin send_idle = 87; recv_idle = 17; end
            if (p == 2) begin send_idle = 0; recv_idle = 0; end
            for (int s = 0; s < 3; s++) begin
                random_regs(0);
                run_phase(70);
            end
        end
        run_phase(30);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
